@@ rtl/lmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmsc_pkg
// Shared types, constants and register map for the four-lane mixer with
// soft clipper.
// ----------------------------------------------------------------------------
package lmsc_pkg;

    // Lane and sample geometry
    localparam int LANE_COUNT = 4;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int MAG_W      = SAMPLE_W - 1;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W      = PROD_W + $clog2(LANE_COUNT);

    // Rounding from Q.29 down to Q.15
    localparam int ROUND_SH   = 14;
    localparam int ROUND_HALF = 1 << (ROUND_SH - 1);
    localparam int M_W        = ACC_W + 1 - ROUND_SH;

    // Soft clipper: knee at 0.99, headroom up to full scale
    localparam int CLIP_T     = 32440;
    localparam int CLIP_H     = 328;
    localparam int CLIP_MAX_Q = (1 << MAG_W) - 1 - CLIP_T;
    // Overshoot beyond OVER_MAX always lands on full scale, so clamp it there
    localparam int OVER_W     = 17;
    localparam int OVER_MAX   = (1 << OVER_W) - 1;
    localparam int DEN_W      = OVER_W + 1;
    localparam int Q_W        = 9;
    localparam int NUM_W      = DEN_W + Q_W;

    // Pipeline layout
    localparam int CLIP_PRE    = 4;
    localparam int CLIP_STAGES = CLIP_PRE + Q_W;
    localparam int ST_LANE     = 0;
    localparam int ST_MERGE    = 1;
    localparam int ST_CLIP     = 2;
    localparam int PIPE_STAGES = ST_CLIP + CLIP_STAGES + 1;
    localparam int ST_OUT      = PIPE_STAGES - 1;

    // Register map
    localparam int REG_COUNT = LANE_COUNT + 4;
    localparam int ADDR_W    = $clog2(4 * REG_COUNT);
    localparam int IDX_W     = ADDR_W - 2;
    localparam int APB_W     = 32;

    localparam logic [IDX_W-1:0] REG_GAIN0  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_ACTIVE = IDX_W'(LANE_COUNT);
    localparam logic [IDX_W-1:0] REG_STEREO = IDX_W'(LANE_COUNT + 1);
    localparam logic [IDX_W-1:0] REG_OUT_CH = IDX_W'(LANE_COUNT + 2);
    localparam logic [IDX_W-1:0] REG_PLAY   = IDX_W'(LANE_COUNT + 3);

    localparam int OUT_CH_W = 2;
    localparam logic [OUT_CH_W-1:0] OUT_CH_NONE   = OUT_CH_W'(0);
    localparam logic [OUT_CH_W-1:0] OUT_CH_MONO   = OUT_CH_W'(1);
    localparam logic [OUT_CH_W-1:0] OUT_CH_STEREO = OUT_CH_W'(2);

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16384);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lane0_left;
        logic signed [SAMPLE_W-1:0] lane0_right;
        logic signed [SAMPLE_W-1:0] lane1_left;
        logic signed [SAMPLE_W-1:0] lane1_right;
        logic signed [SAMPLE_W-1:0] lane2_left;
        logic signed [SAMPLE_W-1:0] lane2_right;
        logic signed [SAMPLE_W-1:0] lane3_left;
        logic signed [SAMPLE_W-1:0] lane3_right;
        logic [LANE_COUNT-1:0]      lane_ready_mask;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } out_t;

    typedef struct packed {
        logic [LANE_COUNT-1:0][GAIN_W-1:0] gain;
        logic [LANE_COUNT-1:0]             active;
        logic [LANE_COUNT-1:0]             stereo;
        logic [OUT_CH_W-1:0]               out_ch;
        logic                              play;
    } cfg_t;

    typedef struct packed {
        logic zero;
        logic mono;
    } ctl_t;

endpackage

@@ rtl/lmsc_regs.sv @@
// ----------------------------------------------------------------------------
// lmsc_regs
// APB register file: lane gains, lane masks, output channel count and play
// enable.
// ----------------------------------------------------------------------------
module lmsc_regs
    import lmsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                if (idx == REG_GAIN0 + IDX_W'(i))
                begin
                    cfg_next.gain[i] = pwdata[GAIN_W-1:0];
                end
            end
            unique case (idx)
                REG_ACTIVE: cfg_next.active = pwdata[LANE_COUNT-1:0];
                REG_STEREO: cfg_next.stereo = pwdata[LANE_COUNT-1:0];
                REG_OUT_CH: cfg_next.out_ch = pwdata[OUT_CH_W-1:0];
                REG_PLAY:   cfg_next.play   = pwdata[0];
                default:    ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            if (idx == REG_GAIN0 + IDX_W'(i))
            begin
                prdata = APB_W'(cfg_reg.gain[i]);
            end
        end
        unique case (idx)
            REG_ACTIVE: prdata = APB_W'(cfg_reg.active);
            REG_STEREO: prdata = APB_W'(cfg_reg.stereo);
            REG_OUT_CH: prdata = APB_W'(cfg_reg.out_ch);
            REG_PLAY:   prdata = APB_W'(cfg_reg.play);
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                cfg_reg.gain[i] <= GAIN_UNITY;
            end
            cfg_reg.active <= '0;
            cfg_reg.stereo <= '0;
            cfg_reg.out_ch <= OUT_CH_STEREO;
            cfg_reg.play   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/lmsc_lane.sv @@
// ----------------------------------------------------------------------------
// lmsc_lane
// One playback lane: scales its left and right samples by the lane gain.
// Mono lanes feed the left sample to both products.
// ----------------------------------------------------------------------------
module lmsc_lane
    import lmsc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  sample_t           left,
    input  sample_t           right,
    input  logic [GAIN_W-1:0] gain,
    input  logic              live,
    input  logic              stereo,
    output prod_t             prod_l,
    output prod_t             prod_r
);

    prod_t                  prod_l_reg;
    prod_t                  prod_l_next;
    prod_t                  prod_r_reg;
    prod_t                  prod_r_next;
    sample_t                src_r;
    logic signed [GAIN_W:0] gain_s;

    // Multiply; a lane that is not live contributes nothing
    always_comb
    begin
        src_r  = stereo ? right : left;
        gain_s = $signed({1'b0, gain});
        prod_l_next = '0;
        prod_r_next = '0;
        if (live)
        begin
            prod_l_next = PROD_W'(left) * PROD_W'(gain_s);
            prod_r_next = PROD_W'(src_r) * PROD_W'(gain_s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
    end

    assign prod_l = prod_l_reg;
    assign prod_r = prod_r_reg;

endmodule

@@ rtl/lmsc_merge.sv @@
// ----------------------------------------------------------------------------
// lmsc_merge
// Sums the per-lane products into one exact accumulator per output channel.
// ----------------------------------------------------------------------------
module lmsc_merge
    import lmsc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  prod_t prod_l [LANE_COUNT],
    input  prod_t prod_r [LANE_COUNT],
    output acc_t  acc_l,
    output acc_t  acc_r
);

    acc_t acc_l_reg;
    acc_t acc_l_next;
    acc_t acc_r_reg;
    acc_t acc_r_next;

    // Add the lanes, sign-extended to the accumulator width
    always_comb
    begin
        acc_l_next = '0;
        acc_r_next = '0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            acc_l_next = acc_l_next + ACC_W'(prod_l[i]);
            acc_r_next = acc_r_next + ACC_W'(prod_r[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
        end
    end

    assign acc_l = acc_l_reg;
    assign acc_r = acc_r_reg;

endmodule

@@ rtl/lmsc_clip.sv @@
// ----------------------------------------------------------------------------
// lmsc_clip
// Rounds one channel's accumulator to Q1.15 and applies the soft clipper.
// The knee curve T + H*over/(over+H) uses a pipelined restoring divider
// that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module lmsc_clip
    import lmsc_pkg::*;
(
    input  logic                   clk,
    input  logic [CLIP_STAGES-1:0] en,
    input  acc_t                   acc,
    output sample_t                res
);

    // Magnitude stage
    logic             neg0_reg;
    logic [ACC_W-1:0] mag_reg;
    logic [ACC_W-1:0] mag_next;
    // Rounding stage
    logic             neg1_reg;
    logic [M_W-1:0]   m_reg;
    logic [ACC_W:0]   rnd;
    // Knee stage
    logic              neg2_reg;
    logic              big2_reg;
    logic [MAG_W-1:0]  mlo2_reg;
    logic [OVER_W-1:0] over_reg;
    logic              big_next;
    logic [M_W-1:0]    over_full;
    logic [OVER_W-1:0] over_next;
    // Divider setup (element 0) and divider stages
    logic [DEN_W-1:0]  den_next;
    logic [NUM_W-1:0]  num_next;
    logic              neg_d  [Q_W+1];
    logic              pass_d [Q_W+1];
    logic [MAG_W-1:0]  mlo_d  [Q_W+1];
    logic [DEN_W-1:0]  den_d  [Q_W+1];
    logic [NUM_W-1:0]  rem_d  [Q_W+1];
    logic [Q_W-1:0]    q_d    [Q_W+1];
    logic [NUM_W-1:0]  step_rem [Q_W+1];
    logic [Q_W-1:0]    step_q   [Q_W+1];
    logic [MAG_W-1:0]  mag_out;

    // Take the magnitude
    assign mag_next = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

    // Round halves away from zero
    assign rnd = {1'b0, mag_reg} + (ACC_W+1)'(ROUND_HALF);

    // Find the overshoot past the knee, clamped where it saturates anyway
    always_comb
    begin
        big_next  = m_reg > M_W'(CLIP_T);
        over_full = m_reg - M_W'(CLIP_T);
        over_next = '0;
        if (big_next)
        begin
            if (over_full > M_W'(OVER_MAX))
            begin
                over_next = OVER_W'(OVER_MAX);
            end
            else
            begin
                over_next = over_full[OVER_W-1:0];
            end
        end
    end

    // Build numerator with half-divisor rounding, and the divisor
    assign den_next = DEN_W'(over_reg) + DEN_W'(CLIP_H);
    assign num_next = NUM_W'(over_reg) * NUM_W'(CLIP_H) + NUM_W'(den_next >> 1);

    // One restoring step per stage, most significant quotient bit first
    always_comb
    begin
        step_rem[0] = '0;
        step_q[0]   = '0;
        for (int j = 1; j <= Q_W; j++)
        begin
            if (rem_d[j-1] >= (NUM_W'(den_d[j-1]) << (Q_W - j)))
            begin
                step_rem[j] = rem_d[j-1] - (NUM_W'(den_d[j-1]) << (Q_W - j));
                step_q[j]   = q_d[j-1] | Q_W'(1 << (Q_W - j));
            end
            else
            begin
                step_rem[j] = rem_d[j-1];
                step_q[j]   = q_d[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg0_reg <= acc[ACC_W-1];
            mag_reg  <= mag_next;
        end
        if (en[1])
        begin
            neg1_reg <= neg0_reg;
            m_reg    <= rnd[ACC_W:ROUND_SH];
        end
        if (en[2])
        begin
            neg2_reg <= neg1_reg;
            big2_reg <= big_next;
            mlo2_reg <= m_reg[MAG_W-1:0];
            over_reg <= over_next;
        end
        if (en[3])
        begin
            neg_d[0]  <= neg2_reg;
            pass_d[0] <= !big2_reg;
            mlo_d[0]  <= mlo2_reg;
            den_d[0]  <= den_next;
            rem_d[0]  <= num_next;
            q_d[0]    <= '0;
        end
        for (int j = 1; j <= Q_W; j++)
        begin
            if (en[CLIP_PRE-1+j])
            begin
                neg_d[j]  <= neg_d[j-1];
                pass_d[j] <= pass_d[j-1];
                mlo_d[j]  <= mlo_d[j-1];
                den_d[j]  <= den_d[j-1];
                rem_d[j]  <= step_rem[j];
                q_d[j]    <= step_q[j];
            end
        end
    end

    // Add the knee offset and restore the sign
    assign mag_out = pass_d[Q_W] ? mlo_d[Q_W] : MAG_W'(CLIP_T) + MAG_W'(q_d[Q_W]);
    assign res     = neg_d[Q_W] ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});

`ifndef ASSERT_OFF
    a_div_rem: assert property (@(posedge clk)
        en[CLIP_STAGES-1] |=> rem_d[Q_W] < NUM_W'(den_d[Q_W]))
        else $error("clip divider remainder not below divisor");

    a_div_q: assert property (@(posedge clk)
        en[CLIP_STAGES-1] |=> q_d[Q_W] <= Q_W'(CLIP_MAX_Q))
        else $error("clip quotient exceeds headroom");

    a_pass_knee: assert property (@(posedge clk)
        en[CLIP_STAGES-1] |=> !pass_d[Q_W] || (mlo_d[Q_W] <= MAG_W'(CLIP_T)))
        else $error("clip passthrough value above knee");
`endif

endmodule

@@ rtl/lane_mixer_soft_clip.sv @@
// ----------------------------------------------------------------------------
// lane_mixer_soft_clip
// Four-lane audio mixer with gain, mono/stereo routing and a soft clipper.
// ----------------------------------------------------------------------------
// Takes one frame per clock cycle unless all stages are full and the
// output is stalled. Each frame passes through the lane multipliers, lane
// summing, magnitude, rounding, knee and divider setup, the soft-clip
// divider (one quotient bit per stage) and the output register. Every
// stage holds its own transaction, so bubbles close up behind a stalled
// output and the input keeps accepting until all 16 stages are full.
// Write the registers only while no frame is in flight.
module lane_mixer_soft_clip
    import lmsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    cfg_t                   cfg;
    sample_t                lane_left  [LANE_COUNT];
    sample_t                lane_right [LANE_COUNT];
    logic [LANE_COUNT-1:0]  live;
    ctl_t                   ctl_in;
    prod_t                  prod_l [LANE_COUNT];
    prod_t                  prod_r [LANE_COUNT];
    acc_t                   acc_l;
    acc_t                   acc_r;
    sample_t                res_l;
    sample_t                res_r;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] go;
    logic [PIPE_STAGES-1:0] en;
    ctl_t                   ctl_reg [PIPE_STAGES];
    out_t                   out_reg;
    out_t                   out_next;

    lmsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the lanes
    assign lane_left[0]  = in_data.lane0_left;
    assign lane_right[0] = in_data.lane0_right;
    assign lane_left[1]  = in_data.lane1_left;
    assign lane_right[1] = in_data.lane1_right;
    assign lane_left[2]  = in_data.lane2_left;
    assign lane_right[2] = in_data.lane2_right;
    assign lane_left[3]  = in_data.lane3_left;
    assign lane_right[3] = in_data.lane3_right;

    assign live = in_data.lane_ready_mask & cfg.active;

    // Silence when play is off, no channel is selected or no lane is live
    assign ctl_in.zero = !cfg.play || (cfg.out_ch == OUT_CH_NONE) || (live == '0);
    assign ctl_in.mono = cfg.out_ch == OUT_CH_MONO;

    // Stage handshake: a stage advances when empty or when it drains forward
    always_comb
    begin
        go[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            go[k] = !vld_reg[k] || go[k+1];
        end
        en[0]       = in_valid && go[0];
        vld_next[0] = go[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            en[k]       = vld_reg[k-1] && go[k];
            vld_next[k] = go[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[ST_OUT];
    assign out_data  = out_reg;

    for (genvar i = 0; i < LANE_COUNT; i++)
    begin : g_lane
        lmsc_lane u_lane (
            .clk    (clk),
            .en     (en[ST_LANE]),
            .left   (lane_left[i]),
            .right  (lane_right[i]),
            .gain   (cfg.gain[i]),
            .live   (live[i]),
            .stereo (cfg.stereo[i]),
            .prod_l (prod_l[i]),
            .prod_r (prod_r[i])
        );
    end

    lmsc_merge u_merge (
        .clk    (clk),
        .en     (en[ST_MERGE]),
        .prod_l (prod_l),
        .prod_r (prod_r),
        .acc_l  (acc_l),
        .acc_r  (acc_r)
    );

    lmsc_clip u_clip_l (
        .clk (clk),
        .en  (en[ST_CLIP +: CLIP_STAGES]),
        .acc (acc_l),
        .res (res_l)
    );

    lmsc_clip u_clip_r (
        .clk (clk),
        .en  (en[ST_CLIP +: CLIP_STAGES]),
        .acc (acc_r),
        .res (res_r)
    );

    // Drop silenced channels into the output register
    always_comb
    begin
        out_next.out_left  = res_l;
        out_next.out_right = res_r;
        if (ctl_reg[ST_OUT-1].zero)
        begin
            out_next.out_left  = '0;
            out_next.out_right = '0;
        end
        else if (ctl_reg[ST_OUT-1].mono)
        begin
            out_next.out_right = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Carry the frame control along with the data
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctl_reg[0] <= ctl_in;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (en[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
        if (en[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> $countones(vld_reg) == $past($countones(vld_reg))
            + $past(in_valid && in_ready) - $past(out_valid && out_ready))
        else $error("pipeline occupancy does not match transactions");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ctl_reg[ST_OUT].zero |-> out_data == '0)
        else $error("silenced frame carries nonzero samples");

    a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ctl_reg[ST_OUT].mono |-> out_data.out_right == '0)
        else $error("mono output drives the right channel");
`endif

endmodule
